>>> design/cbf_pkg.sv
package cbf_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned T_W = 17;
  localparam logic [T_W-1:0] STEP_MIN = 17'd1024;
  localparam logic [T_W:0] ONE_FX = 18'd65536;
  localparam logic [T_W-1:0] ONE_T = 17'd65536;
  localparam logic signed [55:0] HALF_FX = 56'sd32768;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // micro-steps of the shared multiplier
  localparam logic [3:0] K_SQ = 4'd0;
  localparam logic [3:0] K_CU = 4'd1;
  localparam logic [3:0] K_X0 = 4'd2;
  localparam logic [3:0] K_X1 = 4'd3;
  localparam logic [3:0] K_X2 = 4'd4;
  localparam logic [3:0] K_X3 = 4'd5;
  localparam logic [3:0] K_X4 = 4'd6;
  localparam logic [3:0] K_X5 = 4'd7;
  localparam logic [3:0] K_Y0 = 4'd8;
  localparam logic [3:0] K_Y1 = 4'd9;
  localparam logic [3:0] K_Y2 = 4'd10;
  localparam logic [3:0] K_Y3 = 4'd11;
  localparam logic [3:0] K_Y4 = 4'd12;
  localparam logic [3:0] K_Y5 = 4'd13;

  typedef struct packed {
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
  } cbf_curve_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } cbf_point_t;

  typedef struct packed {
    logic [T_W-1:0] t;
    logic           last;
  } cbf_job_t;

  typedef struct packed {
    logic queue_empty;
    logic back_active;
  } cbf_status_t;

endpackage

>>> design/cbf_if.sv
interface cbf_curve_if;
  import cbf_pkg::*;
  logic       valid;
  logic       ready;
  cbf_curve_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbf_point_if;
  import cbf_pkg::*;
  logic       valid;
  logic       ready;
  cbf_point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/cubic_bezier_flattener.sv
// 14 multiplies per point through one shared 36x20 multiplier
// the back takes a job only when idle; a curve gives at most MAX_POINTS points
// next curve is taken once all points of the last one have left the evaluator
// rst is synchronous, active high: step returns to 1024, queue and output empty
module cubic_bezier_flattener import cbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [T_W-1:0] cfg_wdata,
  cbf_curve_if.sink      curve_in,
  cbf_point_if.source    point_out
);

  // front: takes curves and walks t, one job per point
  // back: evaluates each job and holds the result in an output register
  cbf_status_t status;
  cbf_curve_t  coords;
  cbf_job_t    push_data;
  cbf_job_t    pop_data;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  logic        back_active;

  assign status = '{queue_empty: q_empty, back_active: back_active};

  cbf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .curve_in  (curve_in),
    .status    (status),
    .q_full    (q_full),
    .q_push    (push),
    .q_data    (push_data),
    .coords    (coords)
  );

  // short job queue between front and back
  cbf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  cbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .coords    (coords),
    .active    (back_active),
    .point_out (point_out)
  );

endmodule

>>> design/cbf_front.sv
module cbf_front import cbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [T_W-1:0]  cfg_wdata,
  cbf_curve_if.sink       curve_in,
  input  cbf_status_t     status,
  input  logic            q_full,
  output logic            q_push,
  output cbf_job_t        q_data,
  output cbf_curve_t      coords
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_POINTS);

  logic [T_W-1:0]   t_step;
  logic             busy;
  logic [T_W-1:0]   t_cur;
  logic [CNT_W-1:0] cnt;
  logic [T_W:0]     t_sum;
  logic [CNT_W-1:0] cnt_inc;
  logic             last;

  assign curve_in.ready = !busy && status.queue_empty && !status.back_active;
  assign t_sum = {1'b0, t_cur} + {1'b0, t_step};
  assign cnt_inc = cnt + 1'b1;
  assign last = (t_sum >= ONE_FX) || (cnt_inc >= CAP);
  assign q_push = busy && !q_full;
  assign q_data = '{t: t_cur, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      t_step <= STEP_MIN;
    end else if (cfg_we) begin
      t_step <= (cfg_wdata < STEP_MIN) ? STEP_MIN : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      t_cur <= '0;
      cnt <= '0;
    end else if (curve_in.valid && curve_in.ready) begin
      busy <= 1'b1;
      t_cur <= '0;
      cnt <= '0;
    end else if (q_push) begin
      if (last) begin
        busy <= 1'b0;
        t_cur <= '0;
      end else begin
        t_cur <= t_sum[T_W-1:0];
      end
      cnt <= cnt_inc;
    end
  end

  // control points, undefined until the first curve
  always_ff @(posedge clk) begin
    if (curve_in.valid && curve_in.ready) begin
      coords <= curve_in.data;
    end
  end

endmodule

>>> design/cbf_queue.sv
module cbf_queue import cbf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cbf_job_t push_data,
  input  logic     pop,
  output cbf_job_t pop_data,
  output logic     full,
  output logic     empty
);

  cbf_job_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> design/cbf_back.sv
module cbf_back import cbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cbf_job_t   q_data,
  output logic       q_pop,
  input  cbf_curve_t coords,
  output logic       active,
  cbf_point_if.source point_out
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WB    = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t              state;
  logic [3:0]          k;
  logic [T_W-1:0]      t;
  logic                last;
  logic [T_W-1:0]      sq;
  logic [T_W-1:0]      cu;
  logic signed [31:0]  c;
  logic signed [33:0]  u;
  logic signed [31:0]  rx;
  logic signed [31:0]  ry;
  logic signed [55:0]  prod;
  logic signed [35:0]  opa;
  logic [18:0]         opb;
  logic signed [34:0]  s;
  logic signed [39:0]  rr;
  logic [T_W-1:0]      t1;
  logic [18:0]         t3;
  logic [18:0]         sq3;

  assign active = (state != S_IDLE);
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign t1 = ONE_T - t;
  assign t3 = {1'b0, t, 1'b0} + {2'b00, t};
  assign sq3 = {1'b0, sq, 1'b0} + {2'b00, sq};
  assign s = 35'(c) + 35'(u);
  assign rr = 40'((prod + HALF_FX) >>> 16);

  always_comb begin
    unique case (k)
      K_SQ: begin opa = 36'(signed'({1'b0, t}));  opb = 19'(t);  end
      K_CU: begin opa = 36'(signed'({1'b0, sq})); opb = 19'(t);  end
      K_X0: begin opa = 36'(coords.p0_x);         opb = 19'(t1); end
      K_X1: begin opa = 36'(coords.p1_x);         opb = t3;      end
      K_X2: begin opa = 36'(s);                   opb = 19'(t1); end
      K_X3: begin opa = 36'(coords.p2_x);         opb = sq3;     end
      K_X4: begin opa = 36'(s);                   opb = 19'(t1); end
      K_X5: begin opa = 36'(coords.p3_x);         opb = 19'(cu); end
      K_Y0: begin opa = 36'(coords.p0_y);         opb = 19'(t1); end
      K_Y1: begin opa = 36'(coords.p1_y);         opb = t3;      end
      K_Y2: begin opa = 36'(s);                   opb = 19'(t1); end
      K_Y3: begin opa = 36'(coords.p2_y);         opb = sq3;     end
      K_Y4: begin opa = 36'(s);                   opb = 19'(t1); end
      K_Y5: begin opa = 36'(coords.p3_y);         opb = 19'(cu); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_ISSUE) begin
      prod <= opa * signed'({1'b0, opb});
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      t <= q_data.t;
      last <= q_data.last;
    end
    if (state == S_WB) begin
      unique case (k)
        K_SQ: sq <= rr[T_W-1:0];
        K_CU: cu <= rr[T_W-1:0];
        K_X0, K_X2, K_X4, K_Y0, K_Y2, K_Y4: c <= rr[31:0];
        K_X1, K_X3, K_Y1, K_Y3: u <= rr[33:0];
        K_X5: rx <= c + rr[31:0];
        K_Y5: ry <= c + rr[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
      point_out.valid <= 1'b0;
    end else begin
      if (point_out.valid && point_out.ready && state != S_OUT) point_out.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            k <= K_SQ;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WB;
        S_WB: begin
          if (k == K_Y5) begin
            state <= S_OUT;
          end else begin
            k <= k + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (!point_out.valid || point_out.ready) begin
            point_out.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!point_out.valid || point_out.ready)) begin
      point_out.data <= '{point_x: rx, point_y: ry, last_point: last};
    end
  end

endmodule

>>> design/cbf_checker.sv
module cbf_checker import cbf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input cbf_point_t out_data
);

  a_reset_clean: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("not idle after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("curve taken while previous curve still open");

  a_no_point_when_idle: assert property (@(posedge clk) disable iff (rst)
    (in_ready && !out_valid) |=> !out_valid)
    else $error("point produced without a curve");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled point changed");

endmodule

bind cubic_bezier_flattener cbf_checker u_cbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (curve_in.valid),
  .in_ready  (curve_in.ready),
  .out_valid (point_out.valid),
  .out_ready (point_out.ready),
  .out_data  (point_out.data)
);
